### rtl/ppid_pkg.sv
// Shared types, constants and register codes of the preset position PID controller.
package ppid_pkg;

    localparam int NumPresets   = 3;
    localparam int GainFracBits = 8;

    localparam int ReqW    = 3;
    localparam int PosW    = 19;
    localparam int GainW   = 16;
    localparam int TgtW    = 16;
    localparam int ErrW    = 20;
    localparam int DerivW  = ErrW + 1;
    localparam int IntegW  = 32;
    localparam int DriveW  = 15;
    localparam int IdxW    = 2;
    localparam int CfgIdxW = 3;

    localparam int PropW = GainW + 1 + ErrW;
    localparam int IntgW = GainW + 1 + IntegW;
    localparam int DervW = GainW + 1 + DerivW;
    localparam int SumW  = IntgW + 1;

    localparam int InDataW  = ((ReqW + PosW + 7) / 8) * 8;
    localparam int OutDataW = ((DriveW + 1 + IdxW + 7) / 8) * 8;

    localparam logic signed [SumW-1:0] DriveMax = SumW'(12000);
    localparam logic signed [SumW-1:0] DriveMin = -SumW'(12000);

    localparam logic [IdxW-1:0] LastIdx = IdxW'(NumPresets - 1);

    localparam logic [GainW-1:0] KpReset    = 16'd512;
    localparam logic [GainW-1:0] KiReset    = 16'd0;
    localparam logic [GainW-1:0] KdReset    = 16'd0;
    localparam logic [TgtW-1:0]  StowReset  = 16'd30000;
    localparam logic [TgtW-1:0]  OneReset   = 16'd26800;
    localparam logic [TgtW-1:0]  TwoReset   = 16'd14000;
    localparam logic [TgtW-1:0]  UntipReset = 16'd6500;
    localparam logic [TgtW-1:0]  TipReset   = 16'd10000;

    typedef enum logic [ReqW-1:0] {
        REQ_NONE  = 3'd0,
        REQ_NEXT  = 3'd1,
        REQ_BACK  = 3'd2,
        REQ_TIP   = 3'd3,
        REQ_UNTIP = 3'd4
    } t_req;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KP    = 3'd0,
        CFG_KI    = 3'd1,
        CFG_KD    = 3'd2,
        CFG_STOW  = 3'd3,
        CFG_ONE   = 3'd4,
        CFG_TWO   = 3'd5,
        CFG_UNTIP = 3'd6,
        CFG_TIP   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [TgtW-1:0] stow;
        logic [TgtW-1:0] one;
        logic [TgtW-1:0] two;
        logic [TgtW-1:0] untip;
        logic [TgtW-1:0] tip;
    } t_targets;

    typedef struct packed {
        logic [GainW-1:0] kp;
        logic [GainW-1:0] ki;
        logic [GainW-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic accept;
        logic load1;
        logic load2;
        logic load3;
    } t_pipe_ctl;

endpackage

### rtl/preset_position_pid_top.sv
// Top level of the preset position PID controller: handshakes, register file, pipeline.
// Pipeline: an input transfer loads the error and integral stage, which feeds the gain
// products stage and then the clamped sum stage. Throughput: one item per cycle while
// the output is ready; each stage holds its own valid bit, so bubbles are absorbed and
// a stalled output blocks the input only once all three stages are full.
// Reset (i_rst_n low, synchronous) empties the pipeline, reloads the gain and target
// registers to their defaults, index 0, target stow, both toggles set, integral cleared.
module preset_position_pid_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [2:0] req_type, [21:3] position, [23:22] zero
    input  logic [ppid_pkg::InDataW-1:0]         s_axis_tdata,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [14:0] drive_mv, [15] hold_brake, [17:16] preset_index, [23:18] zero
    output logic [ppid_pkg::OutDataW-1:0]        m_axis_tdata,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ppid_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [ppid_pkg::GainW-1:0]           i_cfg_data
);

    ppid_pkg::t_targets  r_targets;
    ppid_pkg::t_gains    r_gains;
    ppid_pkg::t_pipe_ctl ctl;

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    logic [ppid_pkg::ReqW-1:0]        in_req;
    logic signed [ppid_pkg::PosW-1:0] in_pos;
    logic [ppid_pkg::TgtW-1:0]        new_target;
    logic [ppid_pkg::IdxW-1:0]        new_index;

    logic signed [ppid_pkg::DriveW-1:0] drive_mv;
    logic                               hold_brake;
    logic [ppid_pkg::IdxW-1:0]          preset_index;

    assign in_req = s_axis_tdata[ppid_pkg::ReqW-1:0];
    assign in_pos = $signed(s_axis_tdata[ppid_pkg::ReqW +: ppid_pkg::PosW]);

    // Register file; writes are always taken, codes all map to a register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp      <= ppid_pkg::KpReset;
            r_gains.ki      <= ppid_pkg::KiReset;
            r_gains.kd      <= ppid_pkg::KdReset;
            r_targets.stow  <= ppid_pkg::StowReset;
            r_targets.one   <= ppid_pkg::OneReset;
            r_targets.two   <= ppid_pkg::TwoReset;
            r_targets.untip <= ppid_pkg::UntipReset;
            r_targets.tip   <= ppid_pkg::TipReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppid_pkg::CFG_KP:    r_gains.kp      <= i_cfg_data;
                ppid_pkg::CFG_KI:    r_gains.ki      <= i_cfg_data;
                ppid_pkg::CFG_KD:    r_gains.kd      <= i_cfg_data;
                ppid_pkg::CFG_STOW:  r_targets.stow  <= i_cfg_data;
                ppid_pkg::CFG_ONE:   r_targets.one   <= i_cfg_data;
                ppid_pkg::CFG_TWO:   r_targets.two   <= i_cfg_data;
                ppid_pkg::CFG_UNTIP: r_targets.untip <= i_cfg_data;
                ppid_pkg::CFG_TIP:   r_targets.tip   <= i_cfg_data;
                default:             r_gains.kp      <= r_gains.kp;
            endcase
        end
    end

    // Pipeline flow: a stage may load when it is empty or its content moves on
    assign rdy3 = !r_v3 || m_axis_tready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;

    assign ctl.accept = s_axis_tvalid && rdy1;
    assign ctl.load1  = rdy1;
    assign ctl.load2  = rdy2;
    assign ctl.load3  = rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Command decode: step the preset index or flip the toggles as each input transfer requests
    ppid_target u_target (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (ctl.accept),
        .i_req     (in_req),
        .i_targets (r_targets),
        .o_target  (new_target),
        .o_index   (new_index)
    );

    // Control law: error, integral, products, then sum, scale and clamp
    ppid_law u_law (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_target       (new_target),
        .i_index        (new_index),
        .i_position     (in_pos),
        .i_gains        (r_gains),
        .o_drive_mv     (drive_mv),
        .o_hold_brake   (hold_brake),
        .o_preset_index (preset_index)
    );

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(ppid_pkg::OutDataW - ppid_pkg::DriveW - 1 - ppid_pkg::IdxW){1'b0}},
                            preset_index, hold_brake, drive_mv};

    // Drive never leaves the clamp window
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (drive_mv <= 15'sd12000) && (drive_mv >= -15'sd12000))
        else $error("drive outside clamp window");

    // Brake follows the reported preset index
    a_brake_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (hold_brake == (preset_index != '0)))
        else $error("brake does not match preset index");

    // Reported index stays within the preset list
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (preset_index <= ppid_pkg::LastIdx))
        else $error("preset index out of range");

    // Input is refused only when every stage holds an item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && !m_axis_tready))
        else $error("input refused with room in the pipeline");

    // A result is offered once an input that enters an empty, free-running pipe has passed every stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready && !r_v1 && !r_v2)
        ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after three cycles");

endmodule

### rtl/ppid_target.sv
// Preset index, toggle flags and target selection from button events.
module ppid_target (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [ppid_pkg::ReqW-1:0]     i_req,
    input  ppid_pkg::t_targets            i_targets,
    output logic [ppid_pkg::TgtW-1:0]     o_target,
    output logic [ppid_pkg::IdxW-1:0]     o_index
);

    logic [ppid_pkg::IdxW-1:0] r_index, n_index;
    logic [ppid_pkg::TgtW-1:0] r_target, n_target;
    logic                      r_tip, n_tip;
    logic                      r_untip, n_untip;

    always_comb begin
        n_index  = r_index;
        n_target = r_target;
        n_tip    = r_tip;
        n_untip  = r_untip;
        case (i_req)
            ppid_pkg::REQ_NEXT, ppid_pkg::REQ_BACK: begin
                if (i_req == ppid_pkg::REQ_NEXT) begin
                    n_index = (r_index >= ppid_pkg::LastIdx) ? '0 : r_index + 1'b1;
                end else begin
                    n_index = (r_index == '0) ? ppid_pkg::LastIdx : r_index - 1'b1;
                end
                if (n_index == '0) begin
                    n_target = i_targets.stow;
                end else if (n_index == ppid_pkg::IdxW'(1)) begin
                    n_target = i_targets.one;
                end else begin
                    n_target = i_targets.two;
                end
                n_tip   = 1'b1;
                n_untip = 1'b1;
            end
            ppid_pkg::REQ_TIP: begin
                n_tip    = ~r_tip;
                n_untip  = 1'b1;
                n_target = r_tip ? i_targets.tip : i_targets.stow;
            end
            ppid_pkg::REQ_UNTIP: begin
                n_untip  = ~r_untip;
                n_tip    = 1'b1;
                n_target = r_untip ? i_targets.untip : i_targets.stow;
            end
            default: begin
                n_index = r_index;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index  <= '0;
            r_target <= ppid_pkg::StowReset;
            r_tip    <= 1'b1;
            r_untip  <= 1'b1;
        end else if (i_accept) begin
            r_index  <= n_index;
            r_target <= n_target;
            r_tip    <= n_tip;
            r_untip  <= n_untip;
        end
    end

    assign o_target = n_target;
    assign o_index  = n_index;

endmodule

### rtl/ppid_law.sv
// PID law: error and integral stage, gain products stage, sum and clamp stage.
module ppid_law (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ppid_pkg::t_pipe_ctl               i_ctl,
    input  logic [ppid_pkg::TgtW-1:0]         i_target,
    input  logic [ppid_pkg::IdxW-1:0]         i_index,
    input  logic signed [ppid_pkg::PosW-1:0]  i_position,
    input  ppid_pkg::t_gains                  i_gains,
    output logic signed [ppid_pkg::DriveW-1:0] o_drive_mv,
    output logic                              o_hold_brake,
    output logic [ppid_pkg::IdxW-1:0]         o_preset_index
);

    logic signed [ppid_pkg::IntegW-1:0] r_integ;
    logic signed [ppid_pkg::ErrW-1:0]   r_last_err;

    logic signed [ppid_pkg::ErrW-1:0]     n_err;
    logic signed [ppid_pkg::IntegW:0]     n_integ_wide;
    logic signed [ppid_pkg::IntegW-1:0]   n_integ;
    logic signed [ppid_pkg::DerivW-1:0]   n_deriv;

    // stage 1
    logic signed [ppid_pkg::ErrW-1:0]   r_s1_err;
    logic signed [ppid_pkg::IntegW-1:0] r_s1_integ;
    logic signed [ppid_pkg::DerivW-1:0] r_s1_deriv;
    logic [ppid_pkg::IdxW-1:0]          r_s1_index;

    // stage 2
    logic signed [ppid_pkg::PropW-1:0] r_s2_prop;
    logic signed [ppid_pkg::IntgW-1:0] r_s2_intg;
    logic signed [ppid_pkg::DervW-1:0] r_s2_derv;
    logic [ppid_pkg::IdxW-1:0]         r_s2_index;

    logic signed [ppid_pkg::SumW-1:0] n_sum;
    logic signed [ppid_pkg::SumW-1:0] n_scaled;
    logic signed [ppid_pkg::DriveW-1:0] n_drive;

    // stage 3
    logic signed [ppid_pkg::DriveW-1:0] r_drive;
    logic [ppid_pkg::IdxW-1:0]          r_s3_index;

    always_comb begin
        n_err = $signed({4'b0000, i_target})
              - $signed({{(ppid_pkg::ErrW - ppid_pkg::PosW){i_position[ppid_pkg::PosW-1]}},
                         i_position});
        n_integ_wide = $signed({r_integ[ppid_pkg::IntegW-1], r_integ})
                     + $signed({{(ppid_pkg::IntegW + 1 - ppid_pkg::ErrW){n_err[ppid_pkg::ErrW-1]}},
                                n_err});
        // saturate when the two top bits disagree
        if (n_integ_wide[ppid_pkg::IntegW] != n_integ_wide[ppid_pkg::IntegW-1]) begin
            n_integ = n_integ_wide[ppid_pkg::IntegW]
                    ? {1'b1, {(ppid_pkg::IntegW-1){1'b0}}}
                    : {1'b0, {(ppid_pkg::IntegW-1){1'b1}}};
        end else begin
            n_integ = n_integ_wide[ppid_pkg::IntegW-1:0];
        end
        n_deriv = $signed({n_err[ppid_pkg::ErrW-1], n_err})
                - $signed({r_last_err[ppid_pkg::ErrW-1], r_last_err});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else if (i_ctl.accept) begin
            r_integ    <= n_integ;
            r_last_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load1) begin
            r_s1_err   <= n_err;
            r_s1_integ <= n_integ;
            r_s1_deriv <= n_deriv;
            r_s1_index <= i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load2) begin
            r_s2_prop  <= ppid_pkg::PropW'($signed({1'b0, i_gains.kp}))
                        * ppid_pkg::PropW'(r_s1_err);
            r_s2_intg  <= ppid_pkg::IntgW'($signed({1'b0, i_gains.ki}))
                        * ppid_pkg::IntgW'(r_s1_integ);
            r_s2_derv  <= ppid_pkg::DervW'($signed({1'b0, i_gains.kd}))
                        * ppid_pkg::DervW'(r_s1_deriv);
            r_s2_index <= r_s1_index;
        end
    end

    always_comb begin
        n_sum = ppid_pkg::SumW'(r_s2_prop) + ppid_pkg::SumW'(r_s2_intg)
              + ppid_pkg::SumW'(r_s2_derv);
        n_scaled = n_sum >>> ppid_pkg::GainFracBits;
        if (n_scaled > ppid_pkg::DriveMax) begin
            n_drive = ppid_pkg::DriveW'(ppid_pkg::DriveMax);
        end else if (n_scaled < ppid_pkg::DriveMin) begin
            n_drive = ppid_pkg::DriveW'(ppid_pkg::DriveMin);
        end else begin
            n_drive = n_scaled[ppid_pkg::DriveW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load3) begin
            r_drive    <= n_drive;
            r_s3_index <= r_s2_index;
        end
    end

    assign o_drive_mv     = r_drive;
    assign o_hold_brake   = (r_s3_index != '0);
    assign o_preset_index = r_s3_index;

endmodule
